@@ rtl/bf5_pkg.sv @@
// Shared types and constants of the 5x5 box filter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bf5_pkg;

    localparam int WIN         = 5;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int PIX_W       = NUM_CH * CH_W;
    localparam int MAX_WIDTH   = 2048;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 12;
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 13;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int LINES       = WIN - 1;
    localparam int LINE_W      = LINES * PIX_W;

    // Sum widths: a window column of five bytes, then all 25 bytes.
    localparam int CSUM_W      = 11;
    localparam int SUM_W       = 13;
    // Division by 25 as a multiply by round-up(2^17 / 25) and a shift;
    // exact for every sum below 43690.
    localparam int RECIP       = 5243;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = 2 * SUM_W;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    // Stages from the accept edge to the product register of the lanes.
    localparam int TAG_STAGES  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] t_win;
    typedef logic [WIN-1:0][WIN-1:0][CH_W-1:0]  t_chan_win;

    typedef struct packed {
        logic res;
        logic last;
        logic color;
    } t_tag;

    typedef struct packed {
        logic [CH_W-1:0] mean_a;
        logic [CH_W-1:0] mean_b;
        logic [CH_W-1:0] mean_c;
        logic            frame_end;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/bf5_window.sv @@
// Line memory of the four previous lines and the 5x5 pixel window.
// Depends on bf5_pkg.
`default_nettype none

module bf5_window
    import bf5_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [PIX_W-1:0]  i_pix,
    input  wire logic [ADDR_W-1:0] i_col,
    output t_win                   o_win
);

    logic [LINE_W-1:0] r_mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_rd_data;
    logic [LINE_W-1:0] r_fwd_data;
    logic              r_fwd;
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_col;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [LINE_W-1:0] w_old;
    logic [LINE_W-1:0] w_wr_data;
    logic              n_fwd;
    t_win              r_win;

    // A word that reads the column being written in the same cycle gets the
    // new entry from the bypass register instead of the stale memory word.
    assign n_fwd     = i_accept && r_s1_valid && (i_col == r_s1_col);
    assign w_old     = r_fwd ? r_fwd_data : r_rd_data;
    assign w_wr_data = {r_s1_pix, w_old[LINE_W-1:PIX_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            r_fwd      <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_data <= r_mem[i_col];
            r_s1_col  <= i_col;
            r_s1_pix  <= i_pix;
        end
        if (r_s1_valid) begin
            r_mem[r_s1_col] <= w_wr_data;
        end
        r_fwd_data <= w_wr_data;
    end

    // Row 0 is the oldest line, row WIN-1 the current one; column WIN-1 is newest.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN - 1; c++) begin
                    r_win[r][c] <= r_win[r][c+1];
                end
                if (r < LINES) begin
                    r_win[r][WIN-1] <= w_old[r*PIX_W +: PIX_W];
                end else begin
                    r_win[r][WIN-1] <= r_s1_pix;
                end
            end
        end
    end

    assign o_win = r_win;

endmodule

`default_nettype wire

@@ rtl/bf5_lane.sv @@
// One channel lane: registered sum tree over the 25 window bytes and the
// division by 25 through a reciprocal multiply. Depends on bf5_pkg.
`default_nettype none

module bf5_lane
    import bf5_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_chan_win        i_win,
    output logic [CH_W-1:0]       o_mean
);

    logic [WIN-1:0][CSUM_W-1:0] n_csum;
    logic [WIN-1:0][CSUM_W-1:0] r_csum;
    logic [SUM_W-1:0]           n_sum;
    logic [SUM_W-1:0]           r_sum;
    logic [PROD_W-1:0]          r_prod;

    always_comb begin
        for (int c = 0; c < WIN; c++) begin
            n_csum[c] = '0;
            for (int r = 0; r < WIN; r++) begin
                n_csum[c] = n_csum[c] + CSUM_W'(i_win[r][c]);
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int c = 0; c < WIN; c++) begin
            n_sum = n_sum + SUM_W'(r_csum[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_csum <= n_csum;
        r_sum  <= n_sum;
        r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP);
    end

    assign o_mean = r_prod[RECIP_SHIFT +: CH_W];

endmodule

`default_nettype wire

@@ rtl/bf5_out_fifo.sv @@
// Output queue of finished result words with a valid/stall read side.
// Depends on bf5_pkg.
`default_nettype none

module bf5_out_fifo
    import bf5_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_result      o_data
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

@@ rtl/box_filter_5x5.sv @@
// 5x5 box filter: one word in and at most one word out per cycle.
// Each result passes the read, window, column-sum, sum and product registers.
// Throughput: one word per cycle, set by the single read and write per cycle
// of the line memory; input stalls only when the 8-entry output queue is booked.
// Reset clears counters and control, sets the default configuration; the line
// memory is not cleared, the first four lines of each frame fill it.
`default_nettype none

module box_filter_5x5
    import bf5_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [CH_W-1:0]      i_chan_a,
    input  wire logic [CH_W-1:0]      i_chan_b,
    input  wire logic [CH_W-1:0]      i_chan_c,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [CH_W-1:0]           o_mean_a,
    output logic [CH_W-1:0]           o_mean_b,
    output logic [CH_W-1:0]           o_mean_c,
    output logic                      o_frame_end,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic                r_color;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    n_used;
    t_tag                r_tag [TAG_STAGES];
    t_tag                n_tag;

    logic                w_accept;
    logic                w_pop;
    logic                w_push;
    logic [WIDTH_W-1:0]  w_width;
    logic [HEIGHT_W-1:0] w_height;
    logic                w_line_end;
    logic                w_frame_last;
    logic                w_res;
    t_win                w_win;
    t_chan_win           w_chan_win [NUM_CH];
    logic [CH_W-1:0]     w_mean [NUM_CH];
    t_result             w_result;
    t_result             w_out;

    assign w_accept = i_valid && !o_stall;
    assign w_pop    = o_valid && !i_stall;
    // Every result word books a queue entry at accept, so nothing in flight
    // can find the queue full.
    assign o_stall  = (r_used >= CNT_W'(FIFO_DEPTH));

    assign w_width  = (r_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : r_width;
    assign w_height = (r_height > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : r_height;
    assign w_line_end   = (WIDTH_W'(r_col) + WIDTH_W'(1)) >= w_width;
    assign w_frame_last = w_line_end && ((HEIGHT_W'(r_row) + HEIGHT_W'(1)) >= w_height);
    assign w_res = (r_row >= ROW_W'(WIN - 1)) && (r_col >= COL_W'(WIN - 1));

    always_comb begin
        n_tag.res   = w_accept && w_res;
        n_tag.last  = w_frame_last;
        n_tag.color = r_color;
    end

    always_comb begin
        n_used = r_used;
        if (n_tag.res && !w_pop) begin
            n_used = r_used + CNT_W'(1);
        end else if (!n_tag.res && w_pop) begin
            n_used = r_used - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color  <= 1'b0;
            r_width  <= WIDTH_W'(640);
            r_height <= HEIGHT_W'(480);
            r_col    <= '0;
            r_row    <= '0;
            r_used   <= '0;
            for (int i = 0; i < TAG_STAGES; i++) begin
                r_tag[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLOR:  r_color  <= i_cfg_data[0];
                    CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                    default:    ;
                endcase
            end
            if (w_accept) begin
                if (w_line_end) begin
                    r_col <= '0;
                    r_row <= w_frame_last ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            r_used   <= n_used;
            r_tag[0] <= n_tag;
            for (int i = 1; i < TAG_STAGES; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    bf5_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_pix    ({i_chan_c, i_chan_b, i_chan_a}),
        .i_col    (r_col[ADDR_W-1:0]),
        .o_win    (w_win)
    );

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN; c++) begin
                    w_chan_win[k][r][c] = w_win[r][c][k*CH_W +: CH_W];
                end
            end
        end
    end

    for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
        bf5_lane u_lane (
            .i_clk  (i_clk),
            .i_win  (w_chan_win[k]),
            .o_mean (w_mean[k])
        );
    end

    // Merge the lanes; in gray mode only channel 0 is reported.
    always_comb begin
        w_result.mean_a    = w_mean[0];
        w_result.mean_b    = r_tag[TAG_STAGES-1].color ? w_mean[1] : '0;
        w_result.mean_c    = r_tag[TAG_STAGES-1].color ? w_mean[2] : '0;
        w_result.frame_end = r_tag[TAG_STAGES-1].last;
    end

    assign w_push = r_tag[TAG_STAGES-1].res;

    bf5_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (w_out)
    );

    assign o_mean_a    = w_out.mean_a;
    assign o_mean_b    = w_out.mean_b;
    assign o_mean_c    = w_out.mean_c;
    assign o_frame_end = w_out.frame_end;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(FIFO_DEPTH))
        else $error("output queue booked beyond its depth");

    a_valid_booked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_used != '0))
        else $error("result word offered without a booked entry");

    a_line_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_line_end) |=> (r_col == '0))
        else $error("column counter did not wrap at line end");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_frame_last) |=> (r_row == '0))
        else $error("row counter did not wrap at frame end");

endmodule

`default_nettype wire

@@ tb/box_filter_5x5_checker.sv @@
// Checker of the 5x5 box filter: watches the configuration port and both word
// channels, predicts each mean word from its own window model and compares.
// Depends on bf5_pkg for widths, register indexes and the result word layout.

module box_filter_5x5_checker
    import bf5_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [CH_W-1:0]      i_chan_a,
    input  wire logic [CH_W-1:0]      i_chan_b,
    input  wire logic [CH_W-1:0]      i_chan_c,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [CH_W-1:0]      i_mean_a,
    input  wire logic [CH_W-1:0]      i_mean_b,
    input  wire logic [CH_W-1:0]      i_mean_c,
    input  wire logic                 i_frame_end,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_means_due,
    output logic [COL_W-1:0]          o_col,
    output logic [ROW_W-1:0]          o_row
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_AREA     = WIN * WIN;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int SHOWN_FAILS  = 10;

    logic                color_on;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PIX_W-1:0]    line_mem [LINES][MAX_WIDTH];
    logic [PIX_W-1:0]    win [WIN][WIN];
    t_result             means_due [$];

    function automatic logic [CH_W-1:0] channel_mean(input int ch);
        int sum;
        sum = 0;
        for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN; c++) begin
                sum += win[r][c][ch*CH_W +: CH_W];
            end
        end
        return CH_W'(sum / WIN_AREA);
    endfunction

    // Shifts one pixel into the window and line memory, queues the mean word
    // it completes, and advances the raster position.
    task automatic slide_window(input logic [PIX_W-1:0] pix);
        int               eff_w;
        int               eff_h;
        int               col;
        logic [PIX_W-1:0] column [WIN];
        logic             line_done;
        logic             frame_done;
        t_result          res;
        eff_w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        eff_h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        col   = int'(o_col);
        for (int r = 0; r < LINES; r++) begin
            column[r] = line_mem[r][col];
        end
        column[LINES] = pix;
        for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN - 1; c++) begin
                win[r][c] = win[r][c+1];
            end
            win[r][WIN-1] = column[r];
        end
        for (int r = 0; r < LINES; r++) begin
            line_mem[r][col] = column[r+1];
        end
        line_done  = (col + 1 >= eff_w);
        frame_done = line_done && (int'(o_row) + 1 >= eff_h);
        if (o_row >= WIN - 1 && o_col >= WIN - 1) begin
            res.mean_a    = channel_mean(0);
            res.mean_b    = color_on ? channel_mean(1) : '0;
            res.mean_c    = color_on ? channel_mean(2) : '0;
            res.frame_end = frame_done;
            means_due.push_back(res);
        end
        if (line_done) begin
            o_col = '0;
            o_row = frame_done ? '0 : o_row + 1'b1;
        end else begin
            o_col = o_col + 1'b1;
        end
    endtask

    task automatic note_failure(input string what, input t_result exp, input t_result got);
        o_fail_count++;
        if (o_fail_count <= SHOWN_FAILS) begin
            $display("%0t ns: %s: expected a=%0d b=%0d c=%0d end=%0b, got a=%0d b=%0d c=%0d end=%0b",
                     $realtime, what, exp.mean_a, exp.mean_b, exp.mean_c, exp.frame_end,
                     got.mean_a, got.mean_b, got.mean_c, got.frame_end);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_means_due  = 0;
        o_col        = '0;
        o_row        = '0;
    end

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result exp;
        if (!i_rst_n) begin
            color_on   = 1'b0;
            width_reg  = WIDTH_W'(RESET_WIDTH);
            height_reg = HEIGHT_W'(RESET_HEIGHT);
            o_col      = '0;
            o_row      = '0;
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN; c++) begin
                    win[r][c] = '0;
                end
            end
            for (int r = 0; r < LINES; r++) begin
                for (int c = 0; c < MAX_WIDTH; c++) begin
                    line_mem[r][c] = '0;
                end
            end
            means_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLOR:  color_on   = i_cfg_data[0];
                    CFG_WIDTH:  width_reg  = i_cfg_data[WIDTH_W-1:0];
                    CFG_HEIGHT: height_reg = i_cfg_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.mean_a    = i_mean_a;
                got.mean_b    = i_mean_b;
                got.mean_c    = i_mean_c;
                got.frame_end = i_frame_end;
                if (means_due.size() == 0) begin
                    note_failure("unexpected mean word", '0, got);
                end else begin
                    exp = means_due.pop_front();
                    if (got.mean_a !== exp.mean_a || got.mean_b !== exp.mean_b ||
                        got.mean_c !== exp.mean_c || got.frame_end !== exp.frame_end) begin
                        note_failure("mean word mismatch", exp, got);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                slide_window({i_chan_c, i_chan_b, i_chan_a});
            end
        end
        o_means_due = means_due.size();
    end

endmodule

@@ tb/tb.sv @@
// Top of the 5x5 box filter testbench: clock, reset, pixel frames, output stalls
// and the verdict. Depends on bf5_pkg, box_filter_5x5 and box_filter_5x5_checker.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bf5_pkg::*;

    localparam int                   CLK_HALF      = 6;
    localparam int                   RESET_CYCLES  = 5;
    localparam int                   WORD_TARGET   = 650;
    localparam int                   TAIL_WORDS    = 70;
    localparam int                   DRAIN_CYCLES  = 12;
    localparam int                   IDLE_LIMIT    = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam logic [CH_W-1:0]      FULL_SCALE    = 8'hFF;

    typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_FULL_SCALE} t_fill;
    typedef enum int {HOLD_ONLY, FLIP_COLOR, TRIM_WIDTH, TRIM_HEIGHT} t_pause;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    logic [CH_W-1:0]      chan_a    = '0;
    logic [CH_W-1:0]      chan_b    = '0;
    logic [CH_W-1:0]      chan_c    = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [CH_W-1:0]      mean_a;
    logic [CH_W-1:0]      mean_b;
    logic [CH_W-1:0]      mean_c;
    logic                 frame_end;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int                   fail_count;
    int                   means_due;
    logic [COL_W-1:0]     frame_col;
    logic [ROW_W-1:0]     frame_row;

    logic                 gaps_on    = 1'b0;
    logic                 stalls_on  = 1'b0;
    int                   words_sent = 0;
    int                   stall_left = 0;
    int                   quiet_cycles = 0;
    logic                 cur_color;
    int                   cur_width;
    int                   cur_height;

    box_filter_5x5 i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (pix_valid),
        .o_stall     (pix_stall),
        .i_chan_a    (chan_a),
        .i_chan_b    (chan_b),
        .i_chan_c    (chan_c),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_mean_a    (mean_a),
        .o_mean_b    (mean_b),
        .o_mean_c    (mean_c),
        .o_frame_end (frame_end),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    box_filter_5x5_checker i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (pix_valid),
        .i_in_stall   (pix_stall),
        .i_chan_a     (chan_a),
        .i_chan_b     (chan_b),
        .i_chan_c     (chan_c),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_mean_a     (mean_a),
        .i_mean_b     (mean_b),
        .i_mean_c     (mean_c),
        .i_frame_end  (frame_end),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_means_due  (means_due),
        .o_col        (frame_col),
        .o_row        (frame_row)
    );

    always #CLK_HALF clk = ~clk;

    // Mostly short bursts, now and then a long one.
    function automatic int burst_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return $urandom_range(1, 3);
        end else if (roll < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CH_W-1:0] next_sample(input t_fill fill);
        int roll;
        roll = $urandom_range(0, 99);
        case (fill)
            FILL_FULL_SCALE: return FULL_SCALE;
            FILL_EXTREME: begin
                if (roll < 40) begin
                    return '0;
                end else if (roll < 80) begin
                    return FULL_SCALE;
                end
                return CH_W'($urandom_range(0, 255));
            end
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 99) < 30) begin
            res_stall <= 1'b1;
            stall_left = burst_len() - 1;
        end else begin
            res_stall <= 1'b0;
        end
    end

    // Ends the run as a failure when neither channel moves a word for too long.
    always @(posedge clk) begin
        if (!rst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("box_filter_5x5 regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    // Upper data bits beyond each register's width are filled at random.
    task automatic set_frame(input logic color, input int w, input int h);
        logic [CFG_W-1:0] data;
        data    = CFG_W'($urandom_range(0, 8191));
        data[0] = color;
        write_reg(CFG_COLOR, data);
        data          = CFG_W'(w);
        data[CFG_W-1] = 1'($urandom_range(0, 1));
        write_reg(CFG_WIDTH, data);
        write_reg(CFG_HEIGHT, CFG_W'(h));
        cur_color  = color;
        cur_width  = w;
        cur_height = h;
    endtask

    task automatic wait_idle();
        wait (means_due == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_pixel(input logic [CH_W-1:0] a, b, c);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 35) ? burst_len() : 0;
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        chan_a    <= a;
        chan_b    <= b;
        chan_c    <= c;
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Holds the sender until every mean word is out, then may change a
    // register mid-frame. Sizes only shrink here, so the line memory
    // never serves a column that this frame has not filled.
    task automatic pause_mid_frame();
        t_pause act;
        pix_valid <= 1'b0;
        wait_idle();
        act = t_pause'($urandom_range(0, 3));
        case (act)
            FLIP_COLOR: begin
                cur_color = ~cur_color;
                write_reg(CFG_COLOR, {{(CFG_W-1){1'b0}}, cur_color});
            end
            TRIM_WIDTH: begin
                if (cur_width > 1) begin
                    cur_width = $urandom_range(1, cur_width - 1);
                    write_reg(CFG_WIDTH, CFG_W'(cur_width));
                end
            end
            TRIM_HEIGHT: begin
                if (cur_height > 1) begin
                    cur_height = $urandom_range(1, cur_height - 1);
                    write_reg(CFG_HEIGHT, CFG_W'(cur_height));
                end
            end
            default: ;
        endcase
    endtask

    // Sends pixels until the raster position wraps to the frame start.
    task automatic run_frame(input t_fill fill, input int pause_at);
        int n;
        logic [CH_W-1:0] a, b, c;
        n = 0;
        do begin
            if (n == pause_at) begin
                pause_mid_frame();
            end
            a = next_sample(fill);
            b = next_sample(fill);
            c = next_sample(fill);
            send_pixel(a, b, c);
            n++;
        end while (!(frame_col == 0 && frame_row == 0));
        pix_valid <= 1'b0;
        wait_idle();
    endtask

    initial begin
        int    w;
        int    h;
        t_fill fill;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Smallest complete frame in color at full scale, then sizes too
        // small for any window, including zero width and zero height.
        write_reg(CFG_SPARE_IDX, {CFG_W{1'b1}});
        set_frame(1'b1, 5, 5);
        run_frame(FILL_FULL_SCALE, -1);
        set_frame(1'b0, 3, 2);
        run_frame(FILL_RANDOM, -1);
        set_frame(1'b1, 0, 3);
        run_frame(FILL_EXTREME, -1);
        set_frame(1'b0, 4, 0);
        run_frame(FILL_RANDOM, -1);

        while (words_sent < WORD_TARGET - TAIL_WORDS) begin
            gaps_on   = $urandom_range(0, 2) != 0;
            stalls_on = $urandom_range(0, 2) != 0;
            case ($urandom_range(0, 19))
                0:       w = $urandom_range(1, 4);
                1, 2, 3: w = $urandom_range(13, 40);
                default: w = $urandom_range(5, 12);
            endcase
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 9);
            fill = t_fill'($urandom_range(0, 1));
            set_frame(1'($urandom_range(0, 1)), w, h);
            if (w * h > 1 && $urandom_range(0, 2) == 0) begin
                run_frame(fill, $urandom_range(1, w * h - 1));
            end else begin
                run_frame(fill, -1);
            end
        end

        // Sizes above the limits for part of the first line, then cut down
        // to a small frame that finishes at full rate.
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        set_frame(1'b1, 4095, 8191);
        repeat (20) begin
            send_pixel(next_sample(FILL_RANDOM), next_sample(FILL_RANDOM),
                       next_sample(FILL_RANDOM));
        end
        pix_valid <= 1'b0;
        wait_idle();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        write_reg(CFG_WIDTH, CFG_W'(10));
        write_reg(CFG_HEIGHT, CFG_W'(6));
        run_frame(FILL_EXTREME, -1);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && means_due == 0) begin
            $display("box_filter_5x5 regression: pass");
        end else begin
            $display("box_filter_5x5 regression: fail");
        end
        $finish;
    end

endmodule
